>>> rtl/core/gbn_pkg.sv
// Shared types and constants for the Go-Back-N sender window.
package gbn_pkg;

  localparam int unsigned WindowSlots     = 16;   // default slot count
  localparam int unsigned MaxOut          = 16;   // hard cap on outstanding packets
  localparam int unsigned MaxPayloadBytes = 1024;
  localparam int unsigned QueueDepth      = 2;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned HdlW  = 16;
  localparam int unsigned LenW  = 11;
  localparam int unsigned WinW  = 5;
  localparam int unsigned TmoW  = 16;
  localparam int unsigned CntW  = 32;
  localparam int unsigned CfgW  = 16;   // widest register
  localparam int unsigned AdvW  = 5;    // ack advance, at most MaxOut

  localparam logic [WinW-1:0] WindowSizeRst   = 5'd16;
  localparam logic [TmoW-1:0] TimeoutTicksRst = 16'd200;

  typedef enum logic [1:0] {
    FUNC_DATA = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [0:0] {
    CFG_WINDOW_SIZE = 1'b0,
    CFG_TIMEOUT     = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_SENT      = 3'd0,
    KIND_REFUSED   = 3'd1,
    KIND_ACK_OK    = 3'd2,
    KIND_ACK_BAD   = 3'd3,
    KIND_RETX_IDLE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_REFUSE,
    OP_ACK_OK,
    OP_ACK_BAD,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_RESEND
  } bk_state_e;

  // Classified command handed from front to back.
  typedef struct packed {
    op_e             op;
    logic [HdlW-1:0] handle;
    logic [LenW-1:0] len;
    logic [SeqW-1:0] ack;
    logic [AdvW-1:0] adv;
  } gbn_cmd_t;

  // Window edges the back end owns and the front end classifies against.
  typedef struct packed {
    logic [SeqW-1:0] base;
    logic [SeqW-1:0] next;
  } gbn_win_t;

  typedef struct packed {
    logic [HdlW-1:0] handle;
    logic [LenW-1:0] len;
  } slot_rec_t;

endpackage

>>> rtl/core/go_back_n_sender_window.sv
// Top level of the Go-Back-N sender window.
//
//   channel   dir  qualifier          beat contents
//   command   in   start & !busy      func, payload_ref, payload_len, ack_number
//   result    out  out_strobe_o       kind, seq/ref/len out, send_valid, window state,
//                                     counters, last
//   config    in   cfg_we_i           cfg_index_i selects register, cfg_wdata_i value
//
// A command beat is classified and queued on its accept edge; the back end executes it
// on the next edge and its result is on the ports in the cycle after that.
// Offers, acks and plain ticks free the queue once the back end takes them. A tick that
// times out walks the outstanding slots through the one read port, one resend per cycle.
// busy covers the queue and the walk; results cannot be stalled, one cycle each.
// Reset clears window, timer and counters; slot memory is only read behind a send.
module go_back_n_sender_window #(
  parameter int unsigned WINDOW_SLOTS = gbn_pkg::WindowSlots
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                func_i,
  input  logic [15:0]               payload_ref_i,
  input  logic [10:0]               payload_len_i,
  input  logic [31:0]               ack_number_i,
  // config
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_index_i,
  input  logic [gbn_pkg::CfgW-1:0]  cfg_wdata_i,
  // result
  output logic                      out_strobe_o,
  output logic [2:0]                kind_o,
  output logic [31:0]               seq_out_o,
  output logic [15:0]               ref_out_o,
  output logic [10:0]               len_out_o,
  output logic                      send_valid_o,
  output logic [31:0]               window_base_o,
  output logic [31:0]               next_sequence_o,
  output logic                      all_acked_o,
  output logic [31:0]               sent_count_o,
  output logic [31:0]               resent_count_o,
  output logic [31:0]               ack_count_o,
  output logic                      last_o
);
  import gbn_pkg::*;

  logic [WinW-1:0] window_size_q;
  logic [TmoW-1:0] timeout_ticks_q;

  logic     push;
  gbn_cmd_t front_cmd;
  gbn_cmd_t head_cmd;
  logic     q_empty;
  logic     pop;
  gbn_win_t win;
  logic     back_busy;

  // config registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q   <= WindowSizeRst;
      timeout_ticks_q <= TimeoutTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_SIZE: window_size_q   <= cfg_wdata_i[WinW-1:0];
        CFG_TIMEOUT:     timeout_ticks_q <= cfg_wdata_i[TmoW-1:0];
        default: ;
      endcase
    end
  end

  // one command in flight at a time: queue holds it until the back end takes it
  assign busy = !q_empty || back_busy;

  gbn_front #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_front (
    .start_i       (start),
    .busy_i        (busy),
    .func_i        (func_i),
    .payload_ref_i (payload_ref_i),
    .payload_len_i (payload_len_i),
    .ack_number_i  (ack_number_i),
    .window_size_i (window_size_q),
    .win_i         (win),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  gbn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty)
  );

  gbn_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (head_cmd),
    .cmd_valid_i     (!q_empty),
    .pop_o           (pop),
    .timeout_ticks_i (timeout_ticks_q),
    .win_o           (win),
    .busy_o          (back_busy),
    .strobe_o        (out_strobe_o),
    .kind_o          (kind_o),
    .seq_out_o       (seq_out_o),
    .ref_out_o       (ref_out_o),
    .len_out_o       (len_out_o),
    .send_valid_o    (send_valid_o),
    .window_base_o   (window_base_o),
    .next_sequence_o (next_sequence_o),
    .all_acked_o     (all_acked_o),
    .sent_count_o    (sent_count_o),
    .resent_count_o  (resent_count_o),
    .ack_count_o     (ack_count_o),
    .last_o          (last_o)
  );

endmodule

>>> rtl/core/gbn_front.sv
// Front end: takes a command beat, decodes it and checks it against the window.
module gbn_front #(
  parameter int unsigned WINDOW_SLOTS = gbn_pkg::WindowSlots
) (
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                func_i,
  input  logic [15:0]               payload_ref_i,
  input  logic [10:0]               payload_len_i,
  input  logic [31:0]               ack_number_i,
  input  logic [gbn_pkg::WinW-1:0]  window_size_i,
  input  gbn_pkg::gbn_win_t         win_i,
  output logic                      push_o,
  output gbn_pkg::gbn_cmd_t         cmd_o
);
  import gbn_pkg::*;

  localparam int unsigned EffCap = (WINDOW_SLOTS < MaxOut) ? WINDOW_SLOTS : MaxOut;

  logic [WinW-1:0] eff_win;
  logic [SeqW-1:0] span;
  logic [SeqW-1:0] adv;
  logic            room;
  logic            ack_ok;
  logic [LenW-1:0] len_sat;

  assign push_o = start_i & ~busy_i;

  always_comb begin
    if (window_size_i == '0) begin
      eff_win = WinW'(1);
    end else if (window_size_i > WinW'(EffCap)) begin
      eff_win = WinW'(EffCap);
    end else begin
      eff_win = window_size_i;
    end
  end

  // span never exceeds MaxOut, so the ack range check is a narrow compare
  assign span    = win_i.next - win_i.base;
  assign adv     = ack_number_i - win_i.base;
  assign room    = span < {{(SeqW-WinW){1'b0}}, eff_win};
  assign ack_ok  = (adv[SeqW-1:AdvW] == '0) && (adv[AdvW-1:0] != '0) &&
                   (adv[AdvW-1:0] <= span[AdvW-1:0]) && (span[SeqW-1:AdvW] == '0);
  assign len_sat = (payload_len_i > LenW'(MaxPayloadBytes)) ? LenW'(MaxPayloadBytes)
                                                             : payload_len_i;

  always_comb begin
    cmd_o.handle = payload_ref_i;
    cmd_o.len    = len_sat;
    cmd_o.ack    = ack_number_i;
    cmd_o.adv    = adv[AdvW-1:0];
    unique case (func_i)
      FUNC_DATA: cmd_o.op = room ? OP_SEND : OP_REFUSE;
      FUNC_ACK:  cmd_o.op = ack_ok ? OP_ACK_OK : OP_ACK_BAD;
      FUNC_TICK: cmd_o.op = OP_TICK;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

>>> rtl/core/gbn_queue.sv
// Short command queue between front and back end.
module gbn_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gbn_pkg::gbn_cmd_t cmd_i,
  input  logic              pop_i,
  output gbn_pkg::gbn_cmd_t cmd_o,
  output logic              empty_o
);
  import gbn_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW_ = $clog2(QueueDepth + 1);

  gbn_cmd_t          entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW_-1:0]  fill_q, fill_d;
  logic              do_push;
  logic              do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign empty_o = (fill_q == '0);
  assign do_push = push_i && (fill_q != CntW_'(QueueDepth));
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q + CntW_'(do_push) - CntW_'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/core/gbn_back.sv
// Back end: window state, slot memory, timer, counters and result register.
module gbn_back #(
  parameter int unsigned WINDOW_SLOTS = gbn_pkg::WindowSlots
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gbn_pkg::gbn_cmd_t         cmd_i,
  input  logic                      cmd_valid_i,
  output logic                      pop_o,
  input  logic [gbn_pkg::TmoW-1:0]  timeout_ticks_i,
  output gbn_pkg::gbn_win_t         win_o,
  output logic                      busy_o,
  output logic                      strobe_o,
  output logic [2:0]                kind_o,
  output logic [31:0]               seq_out_o,
  output logic [15:0]               ref_out_o,
  output logic [10:0]               len_out_o,
  output logic                      send_valid_o,
  output logic [31:0]               window_base_o,
  output logic [31:0]               next_sequence_o,
  output logic                      all_acked_o,
  output logic [31:0]               sent_count_o,
  output logic [31:0]               resent_count_o,
  output logic [31:0]               ack_count_o,
  output logic                      last_o
);
  import gbn_pkg::*;

  localparam int unsigned IdxW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int unsigned SumW = IdxW + 1;

  bk_state_e       state_q, state_d;

  logic [SeqW-1:0] base_q, base_d;
  logic [SeqW-1:0] next_q, next_d;
  logic [IdxW-1:0] base_idx_q, base_idx_d;
  logic [IdxW-1:0] next_idx_q, next_idx_d;
  logic            timer_on_q, timer_on_d;
  logic [TmoW-1:0] elapsed_q, elapsed_d;
  logic [CntW-1:0] sent_q, sent_d;
  logic [CntW-1:0] resent_q, resent_d;
  logic [CntW-1:0] acks_q, acks_d;

  // resend walk
  logic [IdxW-1:0] cur_idx_q, cur_idx_d;
  logic [SeqW-1:0] cur_seq_q, cur_seq_d;
  logic [AdvW-1:0] remain_q, remain_d;

  // result register
  logic            res_strobe_q, res_strobe_d;
  kind_e           res_kind_q, res_kind_d;
  logic [SeqW-1:0] res_seq_q, res_seq_d;
  logic [HdlW-1:0] res_hdl_q, res_hdl_d;
  logic [LenW-1:0] res_len_q, res_len_d;
  logic            res_send_q, res_send_d;
  logic            res_last_q, res_last_d;
  logic            res_mem_q, res_mem_d;

  slot_rec_t       mem_q [WINDOW_SLOTS];
  slot_rec_t       rd_q;
  logic            mem_we;
  logic            rd_en;

  logic            take;
  logic [TmoW-1:0] eff_tmo;
  logic [TmoW-1:0] elapsed_inc;
  logic            fire;
  logic [SeqW-1:0] span_full;
  logic [AdvW-1:0] span;
  logic            go_resend;
  logic [SumW-1:0] ack_sum;
  logic [IdxW-1:0] ack_idx;

  function automatic logic [IdxW-1:0] idx_inc(logic [IdxW-1:0] i);
    return (i == IdxW'(WINDOW_SLOTS - 1)) ? '0 : i + IdxW'(1);
  endfunction

  assign take        = (state_q == BK_IDLE) && cmd_valid_i;
  assign pop_o       = take;
  assign busy_o      = (state_q != BK_IDLE);
  assign eff_tmo     = (timeout_ticks_i == '0) ? TmoW'(1) : timeout_ticks_i;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TmoW'(1);
  assign fire        = timer_on_q && (elapsed_inc >= eff_tmo);
  assign span_full   = next_q - base_q;
  assign span        = span_full[AdvW-1:0];   // outstanding never exceeds MaxOut
  assign go_resend   = take && (cmd_i.op == OP_TICK) && fire && (span != '0);
  assign rd_en       = (state_q == BK_RESEND);

  // ack advance is at most the slot count, so one conditional subtract wraps it
  always_comb begin
    ack_sum = {1'b0, base_idx_q} + SumW'(cmd_i.adv);
    if (ack_sum >= SumW'(WINDOW_SLOTS)) begin
      ack_sum = ack_sum - SumW'(WINDOW_SLOTS);
    end
    ack_idx = ack_sum[IdxW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (go_resend) state_d = BK_RESEND;
      BK_RESEND: if (remain_q == AdvW'(1)) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    base_d       = base_q;
    next_d       = next_q;
    base_idx_d   = base_idx_q;
    next_idx_d   = next_idx_q;
    timer_on_d   = timer_on_q;
    elapsed_d    = elapsed_q;
    sent_d       = sent_q;
    resent_d     = resent_q;
    acks_d       = acks_q;
    cur_idx_d    = cur_idx_q;
    cur_seq_d    = cur_seq_q;
    remain_d     = remain_q;
    res_strobe_d = 1'b0;
    res_kind_d   = res_kind_q;
    res_seq_d    = res_seq_q;
    res_hdl_d    = res_hdl_q;
    res_len_d    = res_len_q;
    res_send_d   = res_send_q;
    res_last_d   = res_last_q;
    res_mem_d    = res_mem_q;
    mem_we       = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          res_strobe_d = 1'b1;
          res_last_d   = 1'b1;
          res_mem_d    = 1'b0;
          res_seq_d    = '0;
          res_hdl_d    = '0;
          res_len_d    = '0;
          res_send_d   = 1'b0;
          res_kind_d   = KIND_RETX_IDLE;
          unique case (cmd_i.op)
            OP_SEND: begin
              mem_we     = 1'b1;
              res_kind_d = KIND_SENT;
              res_seq_d  = next_q;
              res_hdl_d  = cmd_i.handle;
              res_len_d  = cmd_i.len;
              res_send_d = 1'b1;
              sent_d     = sent_q + CntW'(1);
              if (base_q == next_q) begin
                timer_on_d = 1'b1;
                elapsed_d  = '0;
              end
              next_d     = next_q + SeqW'(1);
              next_idx_d = idx_inc(next_idx_q);
            end
            OP_REFUSE:  res_kind_d = KIND_REFUSED;
            OP_ACK_OK: begin
              res_kind_d = KIND_ACK_OK;
              acks_d     = acks_q + CntW'(1);
              base_d     = cmd_i.ack;
              base_idx_d = ack_idx;
              elapsed_d  = '0;
              timer_on_d = (cmd_i.ack != next_q);
              if (cmd_i.ack == next_q) begin
                elapsed_d = elapsed_q;
              end
            end
            OP_ACK_BAD: res_kind_d = KIND_ACK_BAD;
            OP_TICK: begin
              if (timer_on_q) begin
                elapsed_d = fire ? '0 : elapsed_inc;
              end
              if (fire) begin
                resent_d = resent_q + CntW'(span);
              end
              if (go_resend) begin
                // results come from the walk instead
                res_strobe_d = 1'b0;
                cur_idx_d    = base_idx_q;
                cur_seq_d    = base_q;
                remain_d     = span;
              end
            end
            default:    res_kind_d = KIND_RETX_IDLE;
          endcase
        end
      end
      BK_RESEND: begin
        res_strobe_d = 1'b1;
        res_kind_d   = KIND_RETX_IDLE;
        res_seq_d    = cur_seq_q;
        res_send_d   = 1'b1;
        res_mem_d    = 1'b1;
        res_last_d   = (remain_q == AdvW'(1));
        cur_seq_d    = cur_seq_q + SeqW'(1);
        cur_idx_d    = idx_inc(cur_idx_q);
        remain_d     = remain_q - AdvW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      base_q       <= '0;
      next_q       <= '0;
      base_idx_q   <= '0;
      next_idx_q   <= '0;
      timer_on_q   <= 1'b0;
      elapsed_q    <= '0;
      sent_q       <= '0;
      resent_q     <= '0;
      acks_q       <= '0;
      remain_q     <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      next_q       <= next_d;
      base_idx_q   <= base_idx_d;
      next_idx_q   <= next_idx_d;
      timer_on_q   <= timer_on_d;
      elapsed_q    <= elapsed_d;
      sent_q       <= sent_d;
      resent_q     <= resent_d;
      acks_q       <= acks_d;
      remain_q     <= remain_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_idx_q  <= cur_idx_d;
    cur_seq_q  <= cur_seq_d;
    res_kind_q <= res_kind_d;
    res_seq_q  <= res_seq_d;
    res_hdl_q  <= res_hdl_d;
    res_len_q  <= res_len_d;
    res_send_q <= res_send_d;
    res_last_q <= res_last_d;
    res_mem_q  <= res_mem_d;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[next_idx_q] <= '{handle: cmd_i.handle, len: cmd_i.len};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[cur_idx_q];
    end
  end

  assign win_o.base      = base_q;
  assign win_o.next      = next_q;

  assign strobe_o        = res_strobe_q;
  assign kind_o          = res_kind_q;
  assign seq_out_o       = res_seq_q;
  assign ref_out_o       = res_mem_q ? rd_q.handle : res_hdl_q;
  assign len_out_o       = res_mem_q ? rd_q.len : res_len_q;
  assign send_valid_o    = res_send_q;
  assign last_o          = res_last_q;
  // state is final by the time a result shows and holds until the next command pops
  assign window_base_o   = base_q;
  assign next_sequence_o = next_q;
  assign all_acked_o     = (base_q == next_q);
  assign sent_count_o    = sent_q;
  assign resent_count_o  = resent_q;
  assign ack_count_o     = acks_q;

endmodule

>>> verif/gbn_window_checker.sv
// Scoreboard for the Go-Back-N sender window: predicts result beats and compares them.
module gbn_window_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                func_i,
  input  logic [gbn_pkg::HdlW-1:0]  payload_ref_i,
  input  logic [gbn_pkg::LenW-1:0]  payload_len_i,
  input  logic [gbn_pkg::SeqW-1:0]  ack_number_i,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_index_i,
  input  logic [gbn_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      out_strobe_i,
  input  logic [2:0]                kind_i,
  input  logic [gbn_pkg::SeqW-1:0]  seq_out_i,
  input  logic [gbn_pkg::HdlW-1:0]  ref_out_i,
  input  logic [gbn_pkg::LenW-1:0]  len_out_i,
  input  logic                      send_valid_i,
  input  logic [gbn_pkg::SeqW-1:0]  window_base_i,
  input  logic [gbn_pkg::SeqW-1:0]  next_sequence_i,
  input  logic                      all_acked_i,
  input  logic [gbn_pkg::CntW-1:0]  sent_count_i,
  input  logic [gbn_pkg::CntW-1:0]  resent_count_i,
  input  logic [gbn_pkg::CntW-1:0]  ack_count_i,
  input  logic                      last_i,
  output int                        fail_count_o,
  output int                        expected_left_o,
  output int                        results_seen_o,
  output logic [gbn_pkg::SeqW-1:0]  pred_base_o,
  output logic [gbn_pkg::SeqW-1:0]  pred_next_o
);
  import gbn_pkg::*;

  localparam int unsigned WinCap = (WindowSlots < MaxOut) ? WindowSlots : MaxOut;

  typedef struct packed {
    kind_e           kind;
    logic [SeqW-1:0] seq;
    logic [HdlW-1:0] hdl;
    logic [LenW-1:0] len;
    logic            send;
    logic [SeqW-1:0] base;
    logic [SeqW-1:0] nxt;
    logic            empty;
    logic [CntW-1:0] sent;
    logic [CntW-1:0] resent;
    logic [CntW-1:0] acked;
    logic            last;
  } gbn_result_t;

  gbn_result_t      pending_results[$];

  logic [WinW-1:0]  cfg_win;
  logic [TmoW-1:0]  cfg_tmo;
  logic [SeqW-1:0]  win_base, win_next;
  logic             tmr_run;
  logic [TmoW-1:0]  tmr_ticks;
  logic [HdlW-1:0]  slot_hdl [WindowSlots];
  logic [LenW-1:0]  slot_len [WindowSlots];
  logic [SeqW-1:0]  slot_sq  [WindowSlots];
  logic             slot_busy[WindowSlots];
  logic [CntW-1:0]  n_sent, n_resent, n_acked;
  int               errors;
  int               seen;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Works out every beat one command causes and queues them in order.
  task automatic predict_window_step(input logic [1:0] func, input logic [HdlW-1:0] hdl,
                                     input logic [LenW-1:0] len, input logic [SeqW-1:0] ack);
    gbn_result_t      step_q[$];
    gbn_result_t      r;
    logic [SeqW-1:0]  span, adv, s;
    logic [LenW-1:0]  clen;
    int unsigned      cap, idx, d;
    r = '0;
    case (func)
      FUNC_DATA: begin
        cap = (cfg_win == 0) ? 1 : ((cfg_win > WinCap) ? WinCap : cfg_win);
        if (win_next - win_base < cap) begin
          idx  = win_next % WindowSlots;
          clen = (len > MaxPayloadBytes) ? LenW'(MaxPayloadBytes) : len;
          slot_hdl[idx]  = hdl;
          slot_len[idx]  = clen;
          slot_sq[idx]   = win_next;
          slot_busy[idx] = 1'b1;
          n_sent++;
          if (win_base == win_next) begin
            tmr_run   = 1'b1;
            tmr_ticks = '0;
          end
          r.kind = KIND_SENT;
          r.seq  = win_next;
          r.hdl  = hdl;
          r.len  = clen;
          r.send = 1'b1;
          win_next++;
        end else begin
          r.kind = KIND_REFUSED;
        end
        step_q.push_back(r);
      end
      FUNC_ACK: begin
        adv  = ack - win_base;
        span = win_next - win_base;
        if (adv >= 1 && adv <= span && adv <= MaxOut) begin
          n_acked++;
          for (d = 0; d < adv; d++) slot_busy[(win_base + d) % WindowSlots] = 1'b0;
          win_base = ack;
          if (win_base == win_next) begin
            tmr_run = 1'b0;
          end else begin
            tmr_run   = 1'b1;
            tmr_ticks = '0;
          end
          r.kind = KIND_ACK_OK;
        end else begin
          r.kind = KIND_ACK_BAD;
        end
        step_q.push_back(r);
      end
      FUNC_TICK: begin
        if (tmr_run) begin
          if (tmr_ticks != '1) tmr_ticks++;
          if (tmr_ticks >= cfg_tmo) begin
            span = win_next - win_base;
            if (span > MaxOut) span = MaxOut;
            for (d = 0; d < span; d++) begin
              s   = win_base + d;
              idx = s % WindowSlots;
              if (slot_busy[idx] && slot_sq[idx] == s) begin
                r      = '0;
                r.kind = KIND_RETX_IDLE;
                r.seq  = s;
                r.hdl  = slot_hdl[idx];
                r.len  = slot_len[idx];
                r.send = 1'b1;
                step_q.push_back(r);
                n_resent++;
              end
            end
            tmr_ticks = '0;
          end
        end
        if (step_q.size() == 0) begin
          r      = '0;
          r.kind = KIND_RETX_IDLE;
          step_q.push_back(r);
        end
      end
      default: begin
        r.kind = KIND_RETX_IDLE;
        step_q.push_back(r);
      end
    endcase
    // window state and counters are the post-step values on every beat
    foreach (step_q[k]) begin
      step_q[k].base   = win_base;
      step_q[k].nxt    = win_next;
      step_q[k].empty  = (win_base == win_next);
      step_q[k].sent   = n_sent;
      step_q[k].resent = n_resent;
      step_q[k].acked  = n_acked;
      step_q[k].last   = (k == step_q.size() - 1);
      pending_results.push_back(step_q[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_win   = WindowSizeRst;
      cfg_tmo   = TimeoutTicksRst;
      win_base  = '0;
      win_next  = '0;
      tmr_run   = 1'b0;
      tmr_ticks = '0;
      n_sent    = '0;
      n_resent  = '0;
      n_acked   = '0;
      errors    = 0;
      seen      = 0;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      pending_results.delete();
      fail_count_o    <= 0;
      expected_left_o <= 0;
      results_seen_o  <= 0;
      pred_base_o     <= '0;
      pred_next_o     <= '0;
    end else begin
      if (out_strobe_i) begin
        seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation pending: kind %0d seq 0x%0h",
                 kind_i, seq_out_i);
          errors++;
        end else begin
          gbn_result_t w;
          w = pending_results.pop_front();
          check_field("kind",          32'(w.kind),   32'(kind_i));
          check_field("seq_out",       w.seq,         seq_out_i);
          check_field("ref_out",       32'(w.hdl),    32'(ref_out_i));
          check_field("len_out",       32'(w.len),    32'(len_out_i));
          check_field("send_valid",    32'(w.send),   32'(send_valid_i));
          check_field("window_base",   w.base,        window_base_i);
          check_field("next_sequence", w.nxt,         next_sequence_i);
          check_field("all_acked",     32'(w.empty),  32'(all_acked_i));
          check_field("sent_count",    w.sent,        sent_count_i);
          check_field("resent_count",  w.resent,      resent_count_i);
          check_field("ack_count",     w.acked,       ack_count_i);
          check_field("last",          32'(w.last),   32'(last_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WINDOW_SIZE) cfg_win = cfg_wdata_i[WinW-1:0];
        else                                cfg_tmo = cfg_wdata_i[TmoW-1:0];
      end
      if (start_i && !busy_i)
        predict_window_step(func_i, payload_ref_i, payload_len_i, ack_number_i);
      fail_count_o    <= errors;
      expected_left_o <= pending_results.size();
      results_seen_o  <= seen;
      pred_base_o     <= win_base;
      pred_next_o     <= win_next;
    end
  end

endmodule

>>> verif/tb_go_back_n_sender_window.sv
// Testbench top for the Go-Back-N sender window: stimulus, watchdog and verdict.
module tb_go_back_n_sender_window;
  import gbn_pkg::*;

  // func code 3 has no enum member; the block treats it as an idle no-op
  localparam logic [1:0]  FuncUnused   = 2'd3;
  localparam int unsigned SettleCycles = 4;     // back end is done once busy drops
  localparam int unsigned TailCycles   = 20;    // catch stray beats after the last one
  localparam int unsigned StallLimit   = 2000;  // quiet cycles before giving up
  localparam int unsigned PhaseItems   = 55;    // four phases, about 220 random commands
  localparam int unsigned NumPhases    = 4;

  // per-phase settings: window, timeout, sender idle percentage.
  // Phase 2 stands for the receiver-stall phase; results cannot be held off,
  // so the sender runs flat out there.
  int unsigned phase_win [NumPhases] = '{4, 16, 1, 31};
  int unsigned phase_tmo [NumPhases] = '{6, 2, 1, 65535};
  int unsigned phase_idle[NumPhases] = '{0, 53, 0, 29};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start;
  logic             busy;
  logic [1:0]       func_i;
  logic [HdlW-1:0]  payload_ref_i;
  logic [LenW-1:0]  payload_len_i;
  logic [SeqW-1:0]  ack_number_i;
  logic             cfg_we_i;
  logic [0:0]       cfg_index_i;
  logic [CfgW-1:0]  cfg_wdata_i;
  logic             out_strobe_o;
  logic [2:0]       kind_o;
  logic [SeqW-1:0]  seq_out_o;
  logic [HdlW-1:0]  ref_out_o;
  logic [LenW-1:0]  len_out_o;
  logic             send_valid_o;
  logic [SeqW-1:0]  window_base_o;
  logic [SeqW-1:0]  next_sequence_o;
  logic             all_acked_o;
  logic [CntW-1:0]  sent_count_o;
  logic [CntW-1:0]  resent_count_o;
  logic [CntW-1:0]  ack_count_o;
  logic             last_o;

  int               fail_count;
  int               expected_left;
  int               results_seen;
  logic [SeqW-1:0]  pred_base, pred_next;

  int unsigned      idle_pct = 0;
  int unsigned      n_cmds = 0;
  int unsigned      quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  go_back_n_sender_window dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .payload_ref_i   (payload_ref_i),
    .payload_len_i   (payload_len_i),
    .ack_number_i    (ack_number_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_strobe_o    (out_strobe_o),
    .kind_o          (kind_o),
    .seq_out_o       (seq_out_o),
    .ref_out_o       (ref_out_o),
    .len_out_o       (len_out_o),
    .send_valid_o    (send_valid_o),
    .window_base_o   (window_base_o),
    .next_sequence_o (next_sequence_o),
    .all_acked_o     (all_acked_o),
    .sent_count_o    (sent_count_o),
    .resent_count_o  (resent_count_o),
    .ack_count_o     (ack_count_o),
    .last_o          (last_o)
  );

  // Checker sits beside the block and watches all three channels.
  gbn_window_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .func_i          (func_i),
    .payload_ref_i   (payload_ref_i),
    .payload_len_i   (payload_len_i),
    .ack_number_i    (ack_number_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_strobe_i    (out_strobe_o),
    .kind_i          (kind_o),
    .seq_out_i       (seq_out_o),
    .ref_out_i       (ref_out_o),
    .len_out_i       (len_out_o),
    .send_valid_i    (send_valid_o),
    .window_base_i   (window_base_o),
    .next_sequence_i (next_sequence_o),
    .all_acked_i     (all_acked_o),
    .sent_count_i    (sent_count_o),
    .resent_count_i  (resent_count_o),
    .ack_count_i     (ack_count_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left),
    .results_seen_o  (results_seen),
    .pred_base_o     (pred_base),
    .pred_next_o     (pred_next)
  );

  // Watchdog: any command or result beat resets the count. Sender gaps are
  // geometric and a timeout resend emits a beat every cycle, so a long quiet
  // stretch only means a hung handshake.
  always @(posedge clk_i) begin
    if ((start && !busy) || out_strobe_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $error("no beat accepted for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a rising edge. Optional random gap first (start dropped), then
  // the beat is presented and held until an edge sees busy low. With no gap,
  // start stays high straight through, so it gets only one NBA per step.
  task automatic send_command(input logic [1:0] f, input logic [HdlW-1:0] hdl,
                              input logic [LenW-1:0] len, input logic [SeqW-1:0] ack);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= f;
    payload_ref_i <= hdl;
    payload_len_i <= len;
    ack_number_i  <= ack;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    n_cmds++;
  endtask

  // Wait until every predicted beat has come back, then let the block settle.
  // The checker's count is registered, so the first look waits for a clock edge.
  task automatic drain_results();
    forever begin
      @(posedge clk_i);
      if (expected_left == 0) break;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Both registers, back to back; only ever called with the block idle.
  task automatic write_regs(input logic [CfgW-1:0] win, input logic [CfgW-1:0] tmo);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_WINDOW_SIZE;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_index_i <= CFG_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned      pick, sel;
    logic [1:0]       f;
    logic [HdlW-1:0]  hdl;
    logic [LenW-1:0]  len;
    logic [SeqW-1:0]  ack;

    start         <= 1'b0;
    func_i        <= FUNC_TICK;
    payload_ref_i <= '0;
    payload_len_i <= '0;
    ack_number_i  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_WINDOW_SIZE;
    cfg_wdata_i   <= '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, reset config (window 16, timeout 200) ----
    send_command(FUNC_TICK, 16'h0, 11'd0, 32'h0);            // timer stopped: idle tick
    send_command(FuncUnused, 16'hffff, 11'h7ff, 32'hffffffff); // unused code: idle
    send_command(FUNC_ACK, 16'h0, 11'd0, 32'h0);             // empty window, ack ignored
    send_command(FUNC_DATA, 16'h0000, 11'd0, 32'h0);         // zero length goes out as is
    send_command(FUNC_DATA, 16'hffff, 11'h7ff, 32'h0);       // long payload clipped to max
    send_command(FUNC_DATA, 16'h1234, 11'd1024, 32'h0);
    send_command(FUNC_DATA, 16'h5555, 11'd1, 32'h0);
    send_command(FUNC_ACK, 16'h0, 11'd0, 32'd5);             // beyond next: ignored
    send_command(FUNC_ACK, 16'h0, 11'd0, 32'hffffffff);      // wraps far outside window
    send_command(FUNC_ACK, 16'h0, 11'd0, 32'd2);             // partial ack, timer restarts
    send_command(FUNC_TICK, 16'h0, 11'd0, 32'h0);            // not expired yet
    start <= 1'b0;
    drain_results();

    // window zero acts as one, timeout zero fires on every running tick
    write_regs(16'd0, 16'd0);
    send_command(FUNC_DATA, 16'hbeef, 11'd100, 32'h0);       // two outstanding: refused
    send_command(FUNC_TICK, 16'h0, 11'd0, 32'h0);            // resends seq 2 and 3
    send_command(FUNC_ACK, 16'h0, 11'd0, 32'd4);             // all acked, timer stops
    send_command(FUNC_TICK, 16'h0, 11'd0, 32'h0);            // idle
    send_command(FUNC_DATA, 16'haaaa, 11'd512, 32'h0);
    send_command(FUNC_DATA, 16'h5a5a, 11'd3, 32'h0);         // window of one is full
    send_command(FUNC_TICK, 16'h0, 11'd0, 32'h0);            // single resend
    send_command(FUNC_ACK, 16'h0, 11'd0, 32'd5);
    start <= 1'b0;

    // ---- random phases ----
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      write_regs(CfgW'(phase_win[ph]), CfgW'(phase_tmo[ph]));
      idle_pct = phase_idle[ph];
      for (int i = 0; i < PhaseItems; i++) begin
        // unused fields carry junk so every input bit toggles
        hdl  = HdlW'($urandom);
        len  = LenW'($urandom);
        ack  = $urandom;
        pick = $urandom_range(99);
        if (pick < 45) begin
          f   = FUNC_DATA;
          sel = $urandom_range(19);
          if (sel == 0)      len = '0;
          else if (sel == 1) len = LenW'($urandom_range(2047, 1025));
          else               len = LenW'($urandom_range(1024, 1));
        end else if (pick < 75) begin
          // mostly acks that land inside (base, next]; the rest random
          f = FUNC_ACK;
          if ($urandom_range(4) != 0 && pred_next != pred_base)
            ack = pred_base + $urandom_range(pred_next - pred_base, 1);
        end else if (pick < 97) begin
          f = FUNC_TICK;
        end else begin
          f = FuncUnused;
        end
        send_command(f, hdl, len, ack);
      end
      start <= 1'b0;
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Drove %0d commands: directed cases, then %0d config phases across",
             n_cmds, NumPhases);
    $display("several window and timeout settings; %0d result beats compared.",
             results_seen);
    if (fail_count == 0 && expected_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_left != 0) $error("%0d expected result beats never arrived", expected_left);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
